FILE: hdl/kcdld_pkg.sv
// Package for the two-key click, double-click and long-press detector.
// Holds timer widths, register indexes, phase codes, per-key types and the key update function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kcdld_pkg;

  localparam int TIMER_BITS = 11;
  localparam int CFG_BITS   = 10;
  localparam int IDX_BITS   = 2;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  localparam logic [IDX_BITS-1:0] REG_LONG_PRESS    = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_DOUBLE_WINDOW = 2'd1;

  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET    = 10'd100;
  localparam logic [CFG_BITS-1:0] DOUBLE_WINDOW_RESET = 10'd50;

  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_CONFIRM = 2'd1;
  localparam logic [1:0] PHASE_HELD    = 2'd2;

  typedef struct packed {
    logic [1:0]            phase;
    logic [TIMER_BITS-1:0] held;
    logic                  wopen;
    logic [TIMER_BITS-1:0] wticks;
  } key_state_t;

  typedef struct packed {
    key_state_t st;
    logic       single;
    logic       dbl;
    logic       lng;
  } key_result_t;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    sat_inc = (v == TIMER_MAX) ? v : v + 1'b1;
  endfunction

  // One scan tick of one key: press machine first, then the double-click window.
  function automatic key_result_t key_next(
    input key_state_t          cur,
    input logic                level,
    input logic [CFG_BITS-1:0] long_ticks,
    input logic [CFG_BITS-1:0] win_ticks
  );
    key_result_t           r;
    logic [TIMER_BITS-1:0] long_ext;
    logic [TIMER_BITS-1:0] win_ext;
    logic [TIMER_BITS-1:0] wnext;
    r        = '0;
    r.st     = cur;
    long_ext = TIMER_BITS'(long_ticks);
    win_ext  = TIMER_BITS'(win_ticks);

    case (cur.phase)
      PHASE_CONFIRM: begin
        r.st.phase = level ? PHASE_IDLE : PHASE_HELD;
      end
      PHASE_HELD: begin
        if (level && (cur.held < long_ext)) begin
          if (!cur.wopen) begin
            r.st.wopen  = 1'b1;
            r.st.wticks = '0;
          end else begin
            r.dbl       = 1'b1;
            r.st.wopen  = 1'b0;
          end
          r.st.phase = PHASE_IDLE;
        end else if (level && (cur.held > long_ext)) begin
          r.st.phase = PHASE_IDLE;
        end else begin
          r.lng     = (cur.held == long_ext);
          r.st.held = sat_inc(cur.held);
        end
      end
      default: begin
        // The unused phase code behaves as idle.
        r.st.phase = PHASE_IDLE;
        if (!level) begin
          r.st.phase = PHASE_CONFIRM;
          r.st.held  = '0;
        end
      end
    endcase

    wnext = sat_inc(r.st.wticks);
    if (r.st.wopen) begin
      r.st.wticks = wnext;
      if (wnext > win_ext) begin
        r.single   = 1'b1;
        r.st.wopen = 1'b0;
      end
    end
    key_next = r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/key_click_double_long_detector.sv
// Top level of the two-key click, double-click and long-press detector.
// Depends on kcdld_pkg for types, codes and the per-key update function.
//
//   Channel | Direction | Payload
//   in_     | slave     | tdata[0] key_one_level, tdata[1] key_two_level
//   out_    | master    | tdata[5:0] one/two single, double, long pulses
//   cfg_    | write     | cfg_index selects register, cfg_data 10 bits
//
// The key machines update at the accepting edge and the pulses land in the output register
// at the same edge, so a beat is taken every cycle while the output is not stalled.
// Reset (synchronous, active low) puts both keys idle, closes windows and loads the
// default thresholds. A stalled output holds its beat and stalls the input with it.
`timescale 1ns / 1ps
`default_nettype none

module key_click_double_long_detector
  import kcdld_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // Bits from 0: key_one_level, key_two_level, then zero fill.
  input  wire logic [7:0]          in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // Bits from 0: key_one_single, key_one_double, key_one_long,
  // key_two_single, key_two_double, key_two_long, then zero fill.
  output logic [7:0]               out_tdata,
  input  wire logic                cfg_we,
  input  wire logic [IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data
);

  logic [CFG_BITS-1:0] long_ticks_r;
  logic [CFG_BITS-1:0] win_ticks_r;
  key_state_t          key_one_r, key_two_r;
  logic                out_valid_r;
  logic [5:0]          out_bits_r;

  key_result_t key_one_nxt, key_two_nxt;
  logic        in_accept;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_bits_r};

  always_comb begin
    key_one_nxt = key_next(key_one_r, in_tdata[0], long_ticks_r, win_ticks_r);
    key_two_nxt = key_next(key_two_r, in_tdata[1], long_ticks_r, win_ticks_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LONG_PRESS_RESET;
      win_ticks_r  <= DOUBLE_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS:    long_ticks_r <= cfg_data;
        REG_DOUBLE_WINDOW: win_ticks_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_one_r   <= '0;
      key_two_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        key_one_r   <= key_one_nxt.st;
        key_two_r   <= key_two_nxt.st;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_bits_r <= {key_two_nxt.lng, key_two_nxt.dbl, key_two_nxt.single,
                     key_one_nxt.lng, key_one_nxt.dbl, key_one_nxt.single};
    end
  end

`ifndef NO_ASSERTIONS
  // An empty output register never holds the input back.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while output register empty");

  // A double click closes the window, so no single click can follow in the same tick.
  a_one_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_bits_r[0] && out_bits_r[1]))
    else $error("key one single and double in the same beat");

  a_two_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_bits_r[3] && out_bits_r[4]))
    else $error("key two single and double in the same beat");

  // A long pulse is only decided while the key is held, so it stays held afterwards.
  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && key_one_nxt.lng) |=> (key_one_r.phase == PHASE_HELD))
    else $error("key one long pulse without held phase");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/key_click_double_long_detector_tb.sv
// Self-checking testbench for the two-key click, double-click and long-press detector.
// It predicts the pulse beat for every key beat and compares it field by field.
// Depends on kcdld_pkg and key_click_double_long_detector.
`timescale 1ns / 1ps

module key_click_double_long_detector_tb;
  import kcdld_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;

  localparam logic [CFG_BITS-1:0] DEFAULT_LONG   = 10'd100;
  localparam logic [CFG_BITS-1:0] DEFAULT_WINDOW = 10'd50;
  localparam logic [CFG_BITS-1:0] CFG_TOP        = 10'd1023;

  // Indexes past the two real registers; writes there must change nothing.
  localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

  // Key levels packed as {key_two, key_one}; a zero bit means pressed.
  localparam logic [1:0] BOTH_UP   = 2'b11;
  localparam logic [1:0] ONE_DOWN  = 2'b10;
  localparam logic [1:0] TWO_DOWN  = 2'b01;
  localparam logic [1:0] BOTH_DOWN = 2'b00;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                cfg_we     = 1'b0;
  logic [IDX_BITS-1:0] cfg_index  = '0;
  logic [CFG_BITS-1:0] cfg_data   = '0;

  // Predictor state, one entry per key.
  logic [1:0]            key_phase [2];
  logic [TIMER_BITS-1:0] key_held  [2];
  logic                  win_open  [2];
  logic [TIMER_BITS-1:0] win_count [2];
  logic [CFG_BITS-1:0]   long_limit;
  logic [CFG_BITS-1:0]   window_limit;

  logic [7:0] pulses_due [$];
  logic [7:0] pulse_want;
  logic       allow_idle  = 1'b1;
  int         error_count = 0;
  int         quiet_cycles = 0;

  string pulse_field [8] = '{"key_one_single", "key_one_double", "key_one_long",
                             "key_two_single", "key_two_double", "key_two_long",
                             "pad_6", "pad_7"};

  key_click_double_long_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [TIMER_BITS-1:0] bump_timer(input logic [TIMER_BITS-1:0] v);
    return (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Advances one key by a scan tick; returns {long, double, single}.
  function automatic logic [2:0] advance_key(input int k, input logic released);
    logic single;
    logic dbl;
    logic lng;
    single = 1'b0;
    dbl    = 1'b0;
    lng    = 1'b0;
    case (key_phase[k])
      PHASE_CONFIRM: begin
        key_phase[k] = released ? PHASE_IDLE : PHASE_HELD;
      end
      PHASE_HELD: begin
        if (released && key_held[k] < long_limit) begin
          if (!win_open[k]) begin
            win_open[k]  = 1'b1;
            win_count[k] = '0;
          end else begin
            dbl         = 1'b1;
            win_open[k] = 1'b0;
          end
          key_phase[k] = PHASE_IDLE;
        end else if (released && key_held[k] > long_limit) begin
          key_phase[k] = PHASE_IDLE;
        end else begin
          lng         = (key_held[k] == long_limit);
          key_held[k] = bump_timer(key_held[k]);
        end
      end
      default: begin
        key_phase[k] = released ? PHASE_IDLE : PHASE_CONFIRM;
        if (!released) key_held[k] = '0;
      end
    endcase
    if (win_open[k]) begin
      win_count[k] = bump_timer(win_count[k]);
      if (win_count[k] > window_limit) begin
        single      = 1'b1;
        win_open[k] = 1'b0;
      end
    end
    return {lng, dbl, single};
  endfunction

  function automatic logic [7:0] predict_tick(input logic [1:0] lv);
    logic [2:0] one_pulses;
    logic [2:0] two_pulses;
    one_pulses = advance_key(0, lv[0]);
    two_pulses = advance_key(1, lv[1]);
    return {2'b00, two_pulses, one_pulses};
  endfunction

  // All driving tasks start and end just after a falling edge.
  task automatic send_tick(input logic [1:0] lv);
    int gap;
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b000000, lv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pulses_due.push_back(predict_tick(lv));
    @(negedge clk);
  endtask

  task automatic hold_levels(input logic [1:0] lv, input int ticks);
    repeat (ticks) send_tick(lv);
  endtask

  // Stops the key stream and waits until every predicted beat has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pulses_due.size() != 0);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_LONG_PRESS) long_limit = val;
    else if (idx == REG_DOUBLE_WINDOW) window_limit = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [CFG_BITS-1:0] lp, input logic [CFG_BITS-1:0] win);
    wait_drained();
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_DOUBLE_WINDOW, win);
  endtask

  // Key one long press while key two clicks and lets its window run out, at reset values.
  task automatic test_reset_thresholds();
    hold_levels(BOTH_DOWN, 4);
    hold_levels(ONE_DOWN, 100);
    hold_levels(BOTH_UP, 3);
  endtask

  // Glitch, double click on key one, single click on key two.
  task automatic test_clicks();
    set_thresholds(10'd4, 10'd6);
    hold_levels(BOTH_DOWN, 1);
    hold_levels(ONE_DOWN, 2);
    hold_levels(BOTH_UP, 2);
    hold_levels(ONE_DOWN, 3);
    hold_levels(BOTH_UP, 2);
    hold_levels(TWO_DOWN, 3);
    hold_levels(BOTH_UP, 9);
  endtask

  // Key one lets go on the very tick its count meets the threshold.
  task automatic test_release_at_threshold();
    set_thresholds(10'd1, 10'd1);
    hold_levels(BOTH_DOWN, 2);
    hold_levels(ONE_DOWN, 1);
    hold_levels(BOTH_UP, 4);
  endtask

  task automatic test_zero_thresholds();
    set_thresholds(10'd0, 10'd0);
    hold_levels(BOTH_DOWN, 2);
    hold_levels(BOTH_UP, 2);
    hold_levels(BOTH_DOWN, 3);
    hold_levels(BOTH_UP, 2);
    // With a real threshold a click opens a window that closes on its first tick.
    set_thresholds(10'd5, 10'd0);
    hold_levels(ONE_DOWN, 3);
    hold_levels(TWO_DOWN, 3);
    hold_levels(BOTH_UP, 3);
  endtask

  task automatic test_spare_indexes();
    set_thresholds(10'd3, 10'd2);
    write_reg(REG_SPARE_LO, CFG_TOP);
    write_reg(REG_SPARE_HI, 10'd0);
    hold_levels(BOTH_DOWN, 3);
    hold_levels(BOTH_UP, 5);
    hold_levels(BOTH_DOWN, 6);
    hold_levels(BOTH_UP, 2);
  endtask

  // A hold well past the threshold gives one long pulse and none after it.
  task automatic test_long_hold();
    set_thresholds(10'd150, 10'd8);
    hold_levels(BOTH_DOWN, 3);
    hold_levels(ONE_DOWN, 160);
    hold_levels(BOTH_UP, 4);
  endtask

  function automatic int pick_span(input logic pressed);
    if (pressed) begin
      case ($urandom_range(0, 7))
        0:       return 1;
        1:       return int'(long_limit) + 2;
        2:       return int'(long_limit) + $urandom_range(1, 4);
        default: return $urandom_range(2, int'(long_limit) + 4);
      endcase
    end
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 2);
    return $urandom_range(1, int'(window_limit) + 3);
  endfunction

  // Press and release runs of random length per key, with occasional one-tick noise.
  task automatic run_random(input int ticks, input bit pause_midway);
    int         span [2];
    logic [1:0] lv;
    logic [1:0] sent;
    lv   = BOTH_UP;
    span = '{1, 1};
    for (int i = 0; i < ticks; i++) begin
      for (int k = 0; k < 2; k++) begin
        if (span[k] == 0) begin
          lv[k]   = ~lv[k];
          span[k] = pick_span(!lv[k]);
        end
        span[k]--;
      end
      sent = lv;
      if ($urandom_range(0, 15) == 0) sent = lv ^ 2'($urandom_range(1, 3));
      if (pause_midway && i == ticks / 2) wait_drained();
      send_tick(sent);
    end
  endtask

  task automatic test_random_phases();
    set_thresholds(10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)));
    run_random(60, 1'b0);
    set_thresholds(10'd0, 10'($urandom_range(0, 4)));
    run_random(60, 1'b1);
    set_thresholds(10'($urandom_range(2, 12)), 10'($urandom_range(2, 12)));
    run_random(60, 1'b0);
    set_thresholds(10'd1, 10'd1);
    run_random(60, 1'b0);
    set_thresholds(10'($urandom_range(1, 16)), 10'($urandom_range(1, 16)));
    run_random(60, 1'b1);
    wait_drained();
    allow_idle = 1'b0;
    set_thresholds(10'($urandom_range(1, 8)), 10'($urandom_range(1, 8)));
    run_random(60, 1'b0);
  endtask

  // Result side stalls in bursts while idling is allowed.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pulses_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %b", $time, out_tdata);
        error_count++;
      end else begin
        pulse_want = pulses_due.pop_front();
        for (int b = 0; b < 8; b++) begin
          if (out_tdata[b] !== pulse_want[b]) begin
            $display("%0t: %s expected %0b actual %0b", $time, pulse_field[b],
                     pulse_want[b], out_tdata[b]);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < 2; k++) begin
      key_phase[k] = PHASE_IDLE;
      key_held[k]  = '0;
      win_open[k]  = 1'b0;
      win_count[k] = '0;
    end
    long_limit   = DEFAULT_LONG;
    window_limit = DEFAULT_WINDOW;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_thresholds();
    test_clicks();
    test_release_at_threshold();
    test_zero_thresholds();
    test_spare_indexes();
    test_long_hold();
    test_random_phases();

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
